>>> src/mrmcs_pkg.sv
// ----------------------------------------------------------------------------
// mrmcs_pkg: shared definitions for the row-max / column-min sum block
// Widths, register indexes and the output saturation helper.
// ----------------------------------------------------------------------------
package mrmcs_pkg;

	localparam int MAX_DIM   = 128;
	localparam int ELEM_W    = 16;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int CNT_W     = IDX_W + 1;
	localparam int SUM_W     = ELEM_W + IDX_W + 1;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_SUM_W = 23;
	localparam int OUT_IDX_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

	typedef logic signed [SUM_W-1:0]     sum_t;
	typedef logic signed [OUT_SUM_W-1:0] out_sum_t;
	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [CNT_W-1:0]            cnt_t;

	// Counts of zero act as one, counts above the array size act as the array size.
	function automatic cnt_t clamp_count(logic [CFG_W-1:0] v);
		cnt_t r;
		if (v == '0) begin
			r = cnt_t'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = cnt_t'(MAX_DIM);
		end else begin
			r = cnt_t'(v);
		end
		return r;
	endfunction

	// Clip a running sum to the output field range.
	function automatic out_sum_t sat_sum(sum_t s);
		logic signed [63:0] w;
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		w  = 64'(s);
		hi = (64'sd1 <<< (OUT_SUM_W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (w > hi) begin
			w = hi;
		end else if (w < lo) begin
			w = lo;
		end
		return out_sum_t'(w);
	endfunction

endpackage

>>> src/mrmcs_ram.sv
// ----------------------------------------------------------------------------
// mrmcs_ram: generic single-write, single-read synchronous RAM
// Read data is registered and updates only on a read enable.
// ----------------------------------------------------------------------------
module mrmcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/matrix_row_max_col_min_sums.sv
// ----------------------------------------------------------------------------
// matrix_row_max_col_min_sums: largest row sum and smallest column sum
// Streams a matrix in row-major order and reports, after its last element,
// the first row with the largest sum and the first column with the smallest.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ---------------------------------------
//  input     in_valid / in_ready    element_value
//  output    out_valid / out_ready  max_row_sum, max_row_index,
//                                   min_column_sum, min_column_index
//  config    cfg_we (no wait)       cfg_index, cfg_data
//
// One element beat is taken every cycle while in_ready is high. The column
// sums live in one RAM with a registered read; the updated sum is written
// back from stage 1, and a forwarding register covers a one-column matrix.
// A result is registered when the last element of its matrix leaves stage 1.
// The input stalls only while a result waits in the output register, the
// next result is ready behind it and out_ready is low. Reset is immediate.
//
module matrix_row_max_col_min_sums
	import mrmcs_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [ELEM_W-1:0]    element_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [OUT_SUM_W-1:0] max_row_sum,
	output logic [OUT_IDX_W-1:0]        max_row_index,
	output logic signed [OUT_SUM_W-1:0] min_column_sum,
	output logic [OUT_IDX_W-1:0]        min_column_index
);

	// Configuration and element position.
	cnt_t row_count_q;
	cnt_t col_count_q;
	idx_t row_pos_q;
	idx_t col_pos_q;

	// Stage 1: element waiting for its column sum from the RAM.
	logic                     valid_s1;
	logic signed [ELEM_W-1:0] elem_s1;
	idx_t                     col_s1;
	idx_t                     row_s1;
	logic                     last_col_s1;
	logic                     last_row_s1;

	// Write-back forwarding.
	logic fwd_valid_q;
	idx_t fwd_addr_q;
	sum_t fwd_data_q;

	// Running and best values.
	sum_t row_acc_q;
	sum_t best_row_q;
	idx_t best_row_idx_q;
	sum_t best_col_q;
	idx_t best_col_idx_q;

	logic out_valid_q;

	logic accept;
	logic last_col0;
	logic last_row0;
	logic s1_stall;
	logic s1_fire;
	logic s1_done;
	sum_t ram_rdata;
	sum_t col_prev;
	sum_t elem_ext;
	sum_t col_sum;
	sum_t acc_sum;
	logic col_better;
	logic row_better;
	sum_t best_col_n;
	idx_t best_col_idx_n;
	sum_t best_row_n;
	idx_t best_row_idx_n;

	assign accept    = in_valid && in_ready;
	assign last_col0 = (cnt_t'(col_pos_q) + cnt_t'(1)) >= col_count_q;
	assign last_row0 = (cnt_t'(row_pos_q) + cnt_t'(1)) >= row_count_q;

	// A matrix-closing element must find room in the output register.
	assign s1_done  = last_col_s1 && last_row_s1;
	assign s1_stall = valid_s1 && s1_done && out_valid_q && !out_ready;
	assign s1_fire  = valid_s1 && !s1_stall;
	assign in_ready = !s1_stall;

	mrmcs_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_DIM)
	) u_col_ram (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(col_s1),
		.wdata(col_sum),
		.re   (accept),
		.raddr(col_pos_q),
		.rdata(ram_rdata)
	);

	// The RAM returns the old word when the previous element wrote the same
	// column at the read edge, so take the forwarded value instead.
	always_comb begin
		col_prev = (fwd_valid_q && fwd_addr_q == col_s1) ? fwd_data_q : ram_rdata;
		elem_ext = SUM_W'(elem_s1);
		col_sum  = (row_s1 == '0) ? elem_ext : col_prev + elem_ext;
		acc_sum  = row_acc_q + elem_ext;

		col_better     = last_row_s1 && (col_s1 == '0 || col_sum < best_col_q);
		best_col_n     = col_better ? col_sum : best_col_q;
		best_col_idx_n = col_better ? col_s1 : best_col_idx_q;

		row_better     = last_col_s1 && (row_s1 == '0 || acc_sum > best_row_q);
		best_row_n     = row_better ? acc_sum : best_row_q;
		best_row_idx_n = row_better ? row_s1 : best_row_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= cnt_t'(1);
			col_count_q    <= cnt_t'(1);
			row_pos_q      <= '0;
			col_pos_q      <= '0;
			valid_s1       <= 1'b0;
			fwd_valid_q    <= 1'b0;
			row_acc_q      <= '0;
			best_row_q     <= '0;
			best_row_idx_q <= '0;
			best_col_q     <= '0;
			best_col_idx_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (!s1_stall) begin
				valid_s1 <= accept;
			end

			// Element position advances as each beat is taken.
			if (accept) begin
				if (last_col0) begin
					col_pos_q <= '0;
					row_pos_q <= last_row0 ? '0 : row_pos_q + idx_t'(1);
				end else begin
					col_pos_q <= col_pos_q + idx_t'(1);
				end
			end

			if (s1_fire) begin
				fwd_valid_q    <= 1'b1;
				row_acc_q      <= last_col_s1 ? '0 : acc_sum;
				best_row_q     <= s1_done ? '0 : best_row_n;
				best_row_idx_q <= s1_done ? '0 : best_row_idx_n;
				best_col_q     <= s1_done ? '0 : best_col_n;
				best_col_idx_q <= s1_done ? '0 : best_col_idx_n;
			end

			if (s1_fire && s1_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// A register write restarts the matrix.
			if (cfg_we && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT)) begin
				if (cfg_index == REG_ROW_COUNT) begin
					row_count_q <= clamp_count(cfg_data);
				end else begin
					col_count_q <= clamp_count(cfg_data);
				end
				row_pos_q      <= '0;
				col_pos_q      <= '0;
				row_acc_q      <= '0;
				best_row_q     <= '0;
				best_row_idx_q <= '0;
				best_col_q     <= '0;
				best_col_idx_q <= '0;
			end
		end
	end

	// Stage payload and forwarding data need no reset.
	always_ff @(posedge clk) begin
		if (accept && !s1_stall) begin
			elem_s1     <= element_value;
			col_s1      <= col_pos_q;
			row_s1      <= row_pos_q;
			last_col_s1 <= last_col0;
			last_row_s1 <= last_row0;
		end
		if (s1_fire) begin
			fwd_addr_q <= col_s1;
			fwd_data_q <= col_sum;
		end
		if (s1_fire && s1_done) begin
			max_row_sum      <= sat_sum(best_row_n);
			max_row_index    <= OUT_IDX_W'(best_row_idx_n);
			min_column_sum   <= sat_sum(best_col_n);
			min_column_index <= OUT_IDX_W'(best_col_idx_n);
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_t'(row_pos_q) < row_count_q) && (cnt_t'(col_pos_q) < col_count_q))
		else $error("element position beyond the configured matrix size");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_col_s1 && last_row_s1 && out_valid_q))
		else $error("input stalled without a pending result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_col_s1 && last_row_s1))
		else $error("result raised without a matrix-closing element");
`endif

endmodule
